/* rtl/core/ptt_pkg.sv */
// shared types and constants for the page table translator
package ptt_pkg;

  // table geometry (PAGE_BYTES must be a power of two)
  localparam int TABLE_ENTRIES = 32;
  localparam int PAGE_BYTES    = 128;
  localparam int FRAME_COUNT   = 128;

  // field widths
  localparam int VA_W     = 32;
  localparam int TAG_W    = 25;
  localparam int FRAME_W  = 8;
  localparam int SLOT_W   = 5;
  localparam int PA_W     = 15;
  localparam int LIMIT_W  = 6;
  localparam int OFFSET_W = $clog2(PAGE_BYTES);
  localparam int VPN_W    = VA_W - OFFSET_W;
  localparam int CMP_W    = (VPN_W > TAG_W) ? VPN_W : TAG_W;
  localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SEL_W    = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
  localparam int FULL_W   = FRAME_W + OFFSET_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_READ_ONLY  = 2'd1,
    ST_PAGE_FAULT = 2'd2,
    ST_BUS_ERROR  = 2'd3
  } status_t;

  // input beat
  typedef struct packed {
    op_e_t              opcode;
    logic [VA_W-1:0]    virtual_address;
    logic               is_write;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   new_page_tag;
    logic [FRAME_W-1:0] new_frame;
    logic               new_valid;
    logic               new_read_only;
  } in_t;

  // result beat
  typedef struct packed {
    status_t         status;
    logic [PA_W-1:0] physical_address;
  } out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                active;
    op_e_t               opcode;
    logic                is_write;
    logic [CMP_W-1:0]    vpn;
    logic [OFFSET_W-1:0] offset;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    new_tag;
    logic [FRAME_W-1:0]  new_frame;
    logic                new_valid;
    logic                new_ro;
    logic                found;
    logic [FRAME_W-1:0]  frame;
    logic                ro;
  } tok_t;

endpackage

/* rtl/core/ptt_cell.sv */
// one table entry cell: compares or loads as the token passes by
module ptt_cell import ptt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IDX_W-1:0]   cell_idx,
  input  logic [LIMIT_W-1:0] limit,
  input  tok_t               tok_in,
  output tok_t               tok_out
);

  logic [TAG_W-1:0]   tag_r;
  logic [FRAME_W-1:0] frame_r;
  logic               valid_r;
  logic               ro_r;
  logic               use_r;
  logic               dirty_r;
  tok_t               tok_r;
  tok_t               tok_nxt;

  logic in_range;
  logic hit;
  logic load;
  logic success;

  // match and load decode
  always_comb begin
    in_range = SEL_W'(cell_idx) < SEL_W'(limit);
    hit      = tok_in.active && (tok_in.opcode == OP_TRANSLATE) && !tok_in.found &&
               in_range && valid_r && (CMP_W'(tag_r) == tok_in.vpn);
    load     = tok_in.active && (tok_in.opcode == OP_WRITE) &&
               (SEL_W'(tok_in.slot) == SEL_W'(cell_idx));
    success  = hit && !(tok_in.is_write && ro_r) &&
               (frame_r < FRAME_W'(FRAME_COUNT));
  end

  // token update for the neighbor
  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.frame = frame_r;
      tok_nxt.ro    = ro_r;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (load) begin
      tag_r   <= tok_in.new_tag;
      frame_r <= tok_in.new_frame;
    end
  end

  // entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ro_r    <= 1'b0;
      use_r   <= 1'b0;
      dirty_r <= 1'b0;
    end else if (load) begin
      valid_r <= tok_in.new_valid;
      ro_r    <= tok_in.new_ro;
      use_r   <= 1'b0;
      dirty_r <= 1'b0;
    end else if (success) begin
      use_r <= 1'b1;
      if (tok_in.is_write) begin
        dirty_r <= 1'b1;
      end
    end
  end

  // token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

  // a freshly loaded entry starts clean
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (!use_r && !dirty_r))
    else $error("loaded entry not clean");

  // dirty only ever set together with use
  a_dirty_use: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |-> use_r)
    else $error("dirty entry without use");

  // a found token stays found down the row
  a_found_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_in.active && tok_in.found) |=> (tok_r.active && tok_r.found))
    else $error("found flag lost in cell");

endmodule

/* rtl/core/page_table_translator.sv */
// top level of the page table translator: cell row and result stage
//
//  channel  ports                        handshake
//  input    start, busy, in_item         taken when start & !busy
//  result   out_strobe, out_item         one-cycle strobe, no back-pressure
//  config   cfg_we, cfg_wdata            written when cfg_we
//
// A new item is taken every cycle; busy is high only during reset and the cycle after.
// The token walks one cell per cycle through the TABLE_ENTRIES cell registers and then
// passes the result register, so results strobe in input order.
// Reset is synchronous: all entries invalid, the search limit (limit_r) back to 32.
// Results cannot be stalled; the strobe is the only qualifier.
module page_table_translator import ptt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_item,
  output logic               out_strobe,
  output out_t               out_item,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] limit_r;
  logic               busy_r;
  logic               out_strobe_r;
  out_t               out_item_r;
  out_t               out_item_nxt;
  tok_t               chain [TABLE_ENTRIES+1];
  tok_t               last;
  logic [FULL_W-1:0]  full_pa;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // busy set while in reset, cleared once reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // token entering the first cell
  always_comb begin
    chain[0].active    = start && !busy_r;
    chain[0].opcode    = in_item.opcode;
    chain[0].is_write  = in_item.is_write;
    chain[0].vpn       = CMP_W'(in_item.virtual_address >> OFFSET_W);
    chain[0].offset    = in_item.virtual_address[OFFSET_W-1:0];
    chain[0].slot      = in_item.slot;
    chain[0].new_tag   = in_item.new_page_tag;
    chain[0].new_frame = in_item.new_frame;
    chain[0].new_valid = in_item.new_valid;
    chain[0].new_ro    = in_item.new_read_only;
    chain[0].found     = 1'b0;
    chain[0].frame     = '0;
    chain[0].ro        = 1'b0;
  end

  // row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ptt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(IDX_W'(i)),
      .limit   (limit_r),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[TABLE_ENTRIES];

  // result decode, first failing check wins
  always_comb begin
    full_pa                       = {last.frame, last.offset};
    out_item_nxt.status           = ST_OK;
    out_item_nxt.physical_address = '0;
    priority if (last.opcode == OP_WRITE) begin
      out_item_nxt.status = ST_OK;
    end else if (!last.found) begin
      out_item_nxt.status = ST_PAGE_FAULT;
    end else if (last.is_write && last.ro) begin
      out_item_nxt.status = ST_READ_ONLY;
    end else if (last.frame >= FRAME_W'(FRAME_COUNT)) begin
      out_item_nxt.status = ST_BUS_ERROR;
    end else begin
      out_item_nxt.status           = ST_OK;
      out_item_nxt.physical_address = PA_W'(full_pa);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= last.active;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // faults never carry an address
  a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_OK)) |-> (out_item.physical_address == '0))
    else $error("fault result with nonzero address");

  // busy drops in the cycle after reset is released
  a_busy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy stuck after reset");

  // a configuration write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (limit_r == $past(cfg_wdata)))
    else $error("search count not written");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the page table translator: directed and random lookups
module tb_top;
  import ptt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 8;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  in_t                in_item   = '0;
  logic               out_strobe;
  out_t               out_item;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  // mirror of the table and the search-count register
  logic [TAG_W-1:0]   tag_mirror   [TABLE_ENTRIES];
  logic [FRAME_W-1:0] frame_mirror [TABLE_ENTRIES];
  logic               valid_mirror [TABLE_ENTRIES] = '{default: 1'b0};
  logic               ro_mirror    [TABLE_ENTRIES] = '{default: 1'b0};
  logic               used_mirror  [TABLE_ENTRIES] = '{default: 1'b0};
  logic               dirty_mirror [TABLE_ENTRIES] = '{default: 1'b0};
  logic [LIMIT_W-1:0] search_count = LIMIT_RESET;

  out_t expected_q[$];
  int   mismatch_count  = 0;
  int   beats_sent      = 0;
  int   entry_writes    = 0;
  int   lookups         = 0;
  int   settings_used   = 0;
  int   outcome_tally[4] = '{default: 0};
  int   stall_cycles    = 0;

  page_table_translator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected translation for one beat, updates the mirror
  function automatic out_t predict_translation(input in_t b);
    out_t                r;
    int                  lim;
    int                  hit;
    logic [VPN_W-1:0]    vpn;
    logic [OFFSET_W-1:0] ofs;
    r.status = ST_OK;
    r.physical_address = '0;
    if (b.opcode == OP_WRITE) begin
      if (int'(b.slot) < TABLE_ENTRIES) begin
        tag_mirror[b.slot]   = b.new_page_tag;
        frame_mirror[b.slot] = b.new_frame;
        valid_mirror[b.slot] = b.new_valid;
        ro_mirror[b.slot]    = b.new_read_only;
        used_mirror[b.slot]  = 1'b0;
        dirty_mirror[b.slot] = 1'b0;
      end
      entry_writes++;
    end else begin
      vpn = b.virtual_address[VA_W-1:OFFSET_W];
      ofs = b.virtual_address[OFFSET_W-1:0];
      lim = (int'(search_count) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(search_count);
      hit = -1;
      // lowest valid matching entry wins
      for (int i = 0; i < lim; i++) begin
        if (hit < 0 && valid_mirror[i] && tag_mirror[i] == vpn) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_PAGE_FAULT;
      end else if (b.is_write && ro_mirror[hit]) begin
        r.status = ST_READ_ONLY;
      end else if (int'(frame_mirror[hit]) >= FRAME_COUNT) begin
        r.status = ST_BUS_ERROR;
      end else begin
        used_mirror[hit] = 1'b1;
        if (b.is_write) dirty_mirror[hit] = 1'b1;
        r.physical_address = PA_W'(int'(frame_mirror[hit]) * PAGE_BYTES + int'(ofs));
      end
      lookups++;
      outcome_tally[r.status]++;
    end
    return r;
  endfunction

  // beat with every field random
  function automatic in_t noise_beat();
    in_t b;
    b.opcode          = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_TRANSLATE;
    b.virtual_address = $urandom;
    b.is_write        = 1'($urandom_range(0, 1));
    b.slot            = SLOT_W'($urandom);
    b.new_page_tag    = TAG_W'($urandom);
    b.new_frame       = FRAME_W'($urandom);
    b.new_valid       = 1'($urandom_range(0, 1));
    b.new_read_only   = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic in_t entry_beat(input logic [SLOT_W-1:0] slot,
                                     input logic [TAG_W-1:0] tag,
                                     input logic [FRAME_W-1:0] frame,
                                     input logic valid, input logic ro);
    in_t b;
    b = noise_beat();
    b.opcode        = OP_WRITE;
    b.slot          = slot;
    b.new_page_tag  = tag;
    b.new_frame     = frame;
    b.new_valid     = valid;
    b.new_read_only = ro;
    return b;
  endfunction

  function automatic in_t lookup_beat(input logic [TAG_W-1:0] tag,
                                      input logic [OFFSET_W-1:0] ofs, input logic wr);
    in_t b;
    b = noise_beat();
    b.opcode          = OP_TRANSLATE;
    b.virtual_address = {VPN_W'(tag), ofs};
    b.is_write        = wr;
    return b;
  endfunction

  // drive one beat and hold it until taken
  task automatic send_beat(input in_t b);
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_translation(b));
    beats_sent++;
  endtask

  task automatic idle_for(input int n);
    start   <= 1'b0;
    in_item <= noise_beat();
    repeat (n) @(posedge clk);
  endtask

  // hold off until every expected result is back
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_search_count(input logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    search_count = v;
    settings_used++;
  endtask

  // every slot written once, all invalid, so no lookup sees an unwritten entry
  task automatic test_blank_table();
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      send_beat(entry_beat(SLOT_W'(s), TAG_W'($urandom), FRAME_W'($urandom), 1'b0,
                           1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_lookup_extremes();
    send_beat(entry_beat(5'd0, '0, 8'd0, 1'b1, 1'b0));
    send_beat(entry_beat(5'd31, '1, 8'(FRAME_COUNT - 1), 1'b1, 1'b0));
    send_beat(lookup_beat('0, '0, 1'b1));
    send_beat(lookup_beat('1, '1, 1'b0));
  endtask

  // read-only beats bus error, bus error at the first frame past memory
  task automatic test_fault_priority();
    send_beat(entry_beat(5'd2, 25'd5, 8'd10, 1'b1, 1'b1));
    send_beat(entry_beat(5'd3, 25'd6, 8'(FRAME_COUNT), 1'b1, 1'b0));
    send_beat(entry_beat(5'd4, 25'd7, 8'd255, 1'b1, 1'b1));
    send_beat(entry_beat(5'd5, 25'd9, 8'd3, 1'b0, 1'b0));
    send_beat(lookup_beat(25'd5, 7'd1, 1'b1));
    send_beat(lookup_beat(25'd5, '1, 1'b0));
    send_beat(lookup_beat(25'd6, 7'd4, 1'b1));
    send_beat(lookup_beat(25'd7, 7'd5, 1'b1));
    send_beat(lookup_beat(25'd7, 7'd6, 1'b0));
    send_beat(lookup_beat(25'd9, 7'd7, 1'b0));
  endtask

  task automatic test_lowest_match();
    send_beat(entry_beat(5'd6, 25'd20, 8'd50, 1'b1, 1'b0));
    send_beat(entry_beat(5'd7, 25'd20, 8'd60, 1'b1, 1'b0));
    send_beat(lookup_beat(25'd20, 7'd8, 1'b1));
  endtask

  // zero, one, a cut between duplicate tags, and counts past the table
  task automatic test_search_count();
    set_search_count(6'd0);
    send_beat(lookup_beat('0, 7'd9, 1'b0));
    set_search_count(6'd1);
    send_beat(lookup_beat('0, 7'd10, 1'b0));
    send_beat(lookup_beat(25'd20, 7'd11, 1'b0));
    set_search_count(6'd7);
    send_beat(lookup_beat(25'd20, 7'd12, 1'b0));
    set_search_count(6'd63);
    send_beat(lookup_beat('1, 7'd13, 1'b1));
    set_search_count(6'd33);
    send_beat(lookup_beat('1, 7'd14, 1'b0));
    set_search_count(LIMIT_RESET);
  endtask

  // phases of mixed writes and lookups over a small pool of hot tags
  task automatic test_random_traffic();
    logic [TAG_W-1:0]   hot_tags [8];
    logic [LIMIT_W-1:0] phase_limit [8];
    logic [TAG_W-1:0]   tag;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
    int                 eff;
    int                 n_items;
    int                 pick;
    bit                 idle_on;
    phase_limit = '{6'd63, 6'd32, 6'($urandom_range(2, 31)), 6'd0,
                    6'd33, 6'($urandom_range(0, 63)), 6'd1, 6'd32};
    for (int p = 0; p < 8; p++) begin
      set_search_count(phase_limit[p]);
      foreach (hot_tags[h]) hot_tags[h] = TAG_W'($urandom);
      eff     = (int'(phase_limit[p]) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(phase_limit[p]);
      n_items = (eff == 0) ? 60 : 220;
      idle_on = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
        // last phase runs back to back
        if (p != 7 && idle_on && $urandom_range(0, 7) == 0) idle_for($urandom_range(1, 18));
        if (p == 2 && k == 100) wait_idle();
        if ($urandom_range(0, 9) < 3) begin
          slot  = (eff > 0 && $urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, eff - 1))
                                                       : SLOT_W'($urandom);
          tag   = ($urandom_range(0, 19) < 17) ? hot_tags[$urandom_range(0, 7)]
                                               : TAG_W'($urandom);
          frame = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(FRAME_COUNT, 255))
                                              : 8'($urandom_range(0, FRAME_COUNT - 1));
          send_beat(entry_beat(slot, tag, frame, $urandom_range(0, 4) != 0,
                               $urandom_range(0, 2) == 0));
        end else begin
          pick = $urandom_range(0, 19);
          if (pick < 14) tag = hot_tags[$urandom_range(0, 7)];
          else if (pick < 17) tag = tag_mirror[$urandom_range(0, TABLE_ENTRIES - 1)];
          else tag = TAG_W'($urandom);
          send_beat(lookup_beat(tag, OFFSET_W'($urandom), 1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none expected: status %0d addr %h",
                   $time, out_item.status, out_item.physical_address);
      end else begin
        want = expected_q.pop_front();
        if (out_item.status !== want.status ||
            out_item.physical_address !== want.physical_address) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected status %0d addr %h, got status %0d addr %h",
                     $time, want.status, want.physical_address,
                     out_item.status, out_item.physical_address);
        end
      end
    end
  end

  // cycles with no beat taken on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without progress", stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_blank_table();
    test_lookup_extremes();
    test_fault_priority();
    test_lowest_match();
    test_search_count();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d beats: %0d entry writes, %0d lookups, %0d search-count settings",
             beats_sent, entry_writes, lookups, settings_used);
    $display("lookup outcomes: ok %0d, read-only %0d, page fault %0d, bus error %0d",
             outcome_tally[ST_OK], outcome_tally[ST_READ_ONLY],
             outcome_tally[ST_PAGE_FAULT], outcome_tally[ST_BUS_ERROR]);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ptt_pkg.sv
rtl/core/ptt_cell.sv
rtl/core/page_table_translator.sv
tb/sv/tb_top.sv
